[rtl/pbb_pkg.sv]
// Shared types and constants for the page bitmap blitter.
package pbb_pkg;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_BLIT  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Generation tag kept with every stored byte; tag zero is never current.
    localparam int EPOCH_W = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    // Page of a 10-bit read address is taken with a reciprocal multiply;
    // this shift and the product width keep it exact for column counts from 4 up to 256.
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_PROD_W = 28;

    // One stored framebuffer byte with its generation tag.
    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic [7:0]         data;
    } frame_word_t;

endpackage

[rtl/pbb_bank.sv]
// One framebuffer bank: single write port, registered read with write bypass.
module pbb_bank #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  pbb_pkg::frame_word_t wr_word,
    input  logic [ADDR_W-1:0]   rd_addr,
    output pbb_pkg::frame_word_t rd_word
);
    import pbb_pkg::*;

    frame_word_t mem [DEPTH];
    frame_word_t rd_word_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
    end

    // Read port; a write to the same address in the same cycle is passed through.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_word_reg <= wr_word;
        end
        else
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

[rtl/page_bitmap_blitter.sv]
// Top level of the page bitmap blitter: request registers, framebuffer banks, result register.
// done marks the result behind the request register, second stage and result register.
// Throughput: one request per cycle while busy is low; the receiver cannot stall.
// Busy covers a clearing pass over every address of both banks after reset, and after
// every 63rd clear (tag wrap) the pipeline drain followed by the pass.
// Reset (rst_n low, asynchronous) drops all requests in flight and starts the clearing pass.
module page_bitmap_blitter #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic signed [8:0] origin_x,
    input  logic signed [8:0] origin_y,
    input  logic [4:0]        source_page,
    input  logic [7:0]        source_column,
    input  logic [7:0]        source_byte,
    input  logic [9:0]        read_address,
    output logic              done,
    output logic [7:0]        read_data,
    output logic              clipped
);
    import pbb_pkg::*;

    // Even pages live in one bank and odd pages in the other, so the two
    // destination pages of a blit always land in different banks.
    localparam int BANK_ROWS   = (PAGES + 1) / 2;
    localparam int BANK_DEPTH  = BANK_ROWS * COLUMNS;
    localparam int BA_W        = $clog2(BANK_DEPTH);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int STORE_DEPTH = COLUMNS * PAGES;
    localparam int RECIP       = ((1 << RECIP_SHIFT) + COLUMNS - 1) / COLUMNS;
    localparam int CALC_W      = (BA_W > 10) ? BA_W : 10;

    // Control state.
    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg;
    logic               done_reg;
    logic               sweep_reg, sweep_next;
    logic [BA_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;

    // First stage: registered request.
    logic [1:0]         s1_op_reg;
    logic [EPOCH_W-1:0] s1_epoch_reg;
    logic signed [8:0]  s1_ox_reg;
    logic signed [8:0]  s1_oy_reg;
    logic [4:0]         s1_spage_reg;
    logic [7:0]         s1_scol_reg;
    logic [7:0]         s1_src_reg;
    logic [9:0]         s1_raddr_reg;
    logic [7:0]         s1_rpage_reg;

    // Second stage: bank requests waiting for read data.
    logic [1:0]         s2_op_reg;
    logic [EPOCH_W-1:0] s2_epoch_reg;
    logic               s2_en_even_reg, s2_en_odd_reg;
    logic [7:0]         s2_bits_even_reg, s2_bits_odd_reg;
    logic [BA_W-1:0]    s2_addr_even_reg, s2_addr_odd_reg;
    logic               s2_rd_in_range_reg;
    logic               s2_rd_bank_reg;

    // Result register.
    logic [7:0]         read_data_reg;
    logic               clipped_reg;

    logic accept;
    logic sweep_go;

    assign busy   = sweep_reg;
    assign accept = start && !busy;

    // Page of the read address by reciprocal multiply, ahead of the request register.
    logic [RECIP_PROD_W-1:0] rpage_prod;
    assign rpage_prod = RECIP_PROD_W'(read_address) * RECIP_PROD_W'(RECIP);

    // Generation tag and clearing pass. A clear only advances the tag; a tag wrap
    // sweeps both banks back to tag zero once the pipeline has drained.
    always_comb
    begin
        epoch_next     = epoch_reg;
        sweep_next     = sweep_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (accept && (operation == OP_CLEAR))
        begin
            if (epoch_reg == EPOCH_MAX)
            begin
                epoch_next = EPOCH_FIRST;
                sweep_next = 1'b1;
            end
            else
            begin
                epoch_next = epoch_reg + EPOCH_W'(1);
            end
        end
        if (sweep_go)
        begin
            if (sweep_cnt_reg == BA_W'(BANK_DEPTH - 1))
            begin
                sweep_next     = 1'b0;
                sweep_cnt_next = '0;
            end
            else
            begin
                sweep_cnt_next = sweep_cnt_reg + BA_W'(1);
            end
        end
    end

    assign sweep_go      = sweep_reg && !s1_valid_reg && !s2_valid_reg;
    assign s1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            sweep_reg     <= 1'b1;
            sweep_cnt_reg <= '0;
            epoch_reg     <= EPOCH_FIRST;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            done_reg      <= s2_valid_reg;
            sweep_reg     <= sweep_next;
            sweep_cnt_reg <= sweep_cnt_next;
            epoch_reg     <= epoch_next;
        end
    end

    // Request register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= operation;
            s1_epoch_reg <= epoch_reg;
            s1_ox_reg    <= origin_x;
            s1_oy_reg    <= origin_y;
            s1_spage_reg <= source_page;
            s1_scol_reg  <= source_column;
            s1_src_reg   <= source_byte;
            s1_raddr_reg <= read_address;
            s1_rpage_reg <= rpage_prod[RECIP_PROD_W-1:RECIP_SHIFT];
        end
    end

    // Blit geometry: destination column, first page with floor division, row shift.
    logic signed [9:0]  dx;
    logic               dx_ok;
    logic signed [6:0]  dp;
    logic signed [6:0]  dp1;
    logic [2:0]         shift;
    logic               dp_ok, dp1_ok;
    logic [15:0]        shifted;
    logic [7:0]         bits_main, bits_spill;
    logic               is_blit;

    assign dx      = 10'(s1_ox_reg) + $signed({2'b00, s1_scol_reg});
    assign dx_ok   = !dx[9] && (dx[8:0] < 9'(COLUMNS));
    assign dp      = 7'($signed(s1_oy_reg[8:3])) + $signed({2'b00, s1_spage_reg});
    assign dp1     = dp + 7'sd1;
    assign shift   = s1_oy_reg[2:0];
    assign dp_ok   = !dp[6] && (dp[5:0] < 6'(PAGES));
    assign dp1_ok  = !dp1[6] && (dp1[5:0] < 6'(PAGES)) && (shift != 3'd0);
    assign shifted = {8'd0, s1_src_reg} << shift;
    assign bits_main  = shifted[7:0];
    assign bits_spill = shifted[15:8];
    assign is_blit    = (s1_op_reg == OP_BLIT);

    // Bank steering: an odd first page sends the main byte to the odd bank.
    logic               en_even, en_odd;
    logic [7:0]         bits_even, bits_odd;
    logic [5:0]         row_even, row_odd;
    logic [BA_W-1:0]    waddr_even, waddr_odd;

    always_comb
    begin
        if (dp[0])
        begin
            en_even   = dp1_ok;
            en_odd    = dp_ok;
            bits_even = bits_spill;
            bits_odd  = bits_main;
            row_even  = dp1[6:1];
        end
        else
        begin
            en_even   = dp_ok;
            en_odd    = dp1_ok;
            bits_even = bits_main;
            bits_odd  = bits_spill;
            row_even  = dp[6:1];
        end
        row_odd = dp[6:1];
    end

    assign waddr_even = BA_W'(row_even) * BA_W'(COLUMNS) + BA_W'(dx[COL_W-1:0]);
    assign waddr_odd  = BA_W'(row_odd) * BA_W'(COLUMNS) + BA_W'(dx[COL_W-1:0]);

    // Read geometry: bank address is the linear address less ceil(page/2) rows.
    logic [8:0]         rpage_inc;
    logic [CALC_W-1:0]  rd_lin;
    logic               rd_in_range;
    logic [BA_W-1:0]    raddr_bank;

    assign rpage_inc   = {1'b0, s1_rpage_reg} + 9'd1;
    assign rd_lin      = CALC_W'(s1_raddr_reg)
                         - CALC_W'(rpage_inc[8:1]) * CALC_W'(COLUMNS);
    assign raddr_bank  = rd_lin[BA_W-1:0];
    assign rd_in_range = ({22'd0, s1_raddr_reg} < 32'(STORE_DEPTH));

    logic [BA_W-1:0] rd_addr_even, rd_addr_odd;
    assign rd_addr_even = is_blit ? waddr_even : raddr_bank;
    assign rd_addr_odd  = is_blit ? waddr_odd  : raddr_bank;

    // Second stage register.
    always_ff @(posedge clk)
    begin
        s2_op_reg          <= s1_op_reg;
        s2_epoch_reg       <= s1_epoch_reg;
        s2_en_even_reg     <= is_blit && dx_ok && en_even;
        s2_en_odd_reg      <= is_blit && dx_ok && en_odd;
        s2_bits_even_reg   <= bits_even;
        s2_bits_odd_reg    <= bits_odd;
        s2_addr_even_reg   <= waddr_even;
        s2_addr_odd_reg    <= waddr_odd;
        s2_rd_in_range_reg <= rd_in_range;
        s2_rd_bank_reg     <= s1_rpage_reg[0];
    end

    // Banks.
    frame_word_t     word_even, word_odd;
    frame_word_t     wword_even, wword_odd;
    logic            wen_even, wen_odd;
    logic [BA_W-1:0] wa_even, wa_odd;

    pbb_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BA_W)
    ) u_bank_even (
        .clk     (clk),
        .wr_en   (wen_even),
        .wr_addr (wa_even),
        .wr_word (wword_even),
        .rd_addr (rd_addr_even),
        .rd_word (word_even)
    );

    pbb_bank #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BA_W)
    ) u_bank_odd (
        .clk     (clk),
        .wr_en   (wen_odd),
        .wr_addr (wa_odd),
        .wr_word (wword_odd),
        .rd_addr (rd_addr_odd),
        .rd_word (word_odd)
    );

    // Merge: a byte with a stale tag counts as cleared before the OR.
    logic [7:0] cur_even, cur_odd;
    assign cur_even = (word_even.tag == s2_epoch_reg) ? word_even.data : 8'd0;
    assign cur_odd  = (word_odd.tag == s2_epoch_reg) ? word_odd.data : 8'd0;

    // Write ports: the clearing pass owns both banks while the pipeline is empty.
    always_comb
    begin
        if (sweep_go)
        begin
            wen_even   = 1'b1;
            wen_odd    = 1'b1;
            wa_even    = sweep_cnt_reg;
            wa_odd     = sweep_cnt_reg;
            wword_even = '0;
            wword_odd  = '0;
        end
        else
        begin
            wen_even        = s2_valid_reg && s2_en_even_reg;
            wen_odd         = s2_valid_reg && s2_en_odd_reg;
            wa_even         = s2_addr_even_reg;
            wa_odd          = s2_addr_odd_reg;
            wword_even.tag  = s2_epoch_reg;
            wword_even.data = cur_even | s2_bits_even_reg;
            wword_odd.tag   = s2_epoch_reg;
            wword_odd.data  = cur_odd | s2_bits_odd_reg;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            if ((s2_op_reg == OP_READ) && s2_rd_in_range_reg)
            begin
                read_data_reg <= s2_rd_bank_reg ? cur_odd : cur_even;
            end
            else
            begin
                read_data_reg <= 8'd0;
            end
            clipped_reg <= (s2_op_reg == OP_BLIT) && !s2_en_even_reg && !s2_en_odd_reg;
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign clipped   = clipped_reg;

`ifndef NO_ASSERTIONS
    // Every accepted request yields its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("result missing after accepted request");

    // Tag zero marks swept bytes and must never become current.
    a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("generation tag reached zero");

    // A finished clearing pass always leaves the first generation current.
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sweep_reg) |-> (epoch_reg == EPOCH_FIRST))
        else $error("clearing pass ended with wrong generation");

    // A clipped blit result never carries read data.
    a_clip_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && clipped) |-> (read_data == 8'd0))
        else $error("clipped result carries read data");
`endif

endmodule

[dv/page_bitmap_blitter_test.sv]
// Self-checking testbench for the page bitmap blitter: directed and random requests.
module page_bitmap_blitter_test;
    import pbb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB_COLUMNS = 128;
    localparam int FB_PAGES   = 8;
    localparam int FB_DEPTH   = FB_COLUMNS * FB_PAGES;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One drawing request as it appears on the input ports.
    typedef struct {
        logic [1:0]        op;
        logic signed [8:0] ox;
        logic signed [8:0] oy;
        logic [4:0]        spage;
        logic [7:0]        scol;
        logic [7:0]        sbyte;
        logic [9:0]        raddr;
    } draw_request_t;

    // One result as it appears on the output ports.
    typedef struct {
        logic [7:0] data;
        logic       clip;
    } draw_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [1:0]        operation = '0;
    logic signed [8:0] origin_x = '0;
    logic signed [8:0] origin_y = '0;
    logic [4:0]        source_page = '0;
    logic [7:0]        source_column = '0;
    logic [7:0]        source_byte = '0;
    logic [9:0]        read_address = '0;
    logic              done;
    logic [7:0]        read_data;
    logic              clipped;

    // Requests waiting to be driven, and results the framebuffer copy has worked out.
    draw_request_t pending_requests[$];
    draw_result_t  expected_results[$];
    int            recent_addrs[$];

    // Private copy of the framebuffer.
    logic [7:0] fb_bytes [FB_DEPTH];
    bit         fb_live  [FB_DEPTH];

    int idle_pct = 26;
    bit took_request = 1'b0;
    int mismatches = 0;

    page_bitmap_blitter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .source_page   (source_page),
        .source_column (source_column),
        .source_byte   (source_byte),
        .read_address  (read_address),
        .done          (done),
        .read_data     (read_data),
        .clipped       (clipped)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        begin
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // OR bits into one framebuffer byte; a byte left over from before a clear starts at zero.
    function automatic void merge_byte(input int page, input int col, input logic [7:0] bits);
        int addr;
        begin
            addr = page * FB_COLUMNS + col;
            if (!fb_live[addr])
            begin
                fb_bytes[addr] = '0;
                fb_live[addr]  = 1'b1;
            end
            fb_bytes[addr] |= bits;
        end
    endfunction

    // Apply one request to the framebuffer copy and return the result it gives.
    function automatic draw_result_t draw_and_predict(input draw_request_t r);
        draw_result_t res;
        int dx, dp, sh;
        bit wrote;
        logic [7:0] lo_bits, hi_bits;
        begin
            res.data = '0;
            res.clip = 1'b0;
            case (r.op)
                OP_CLEAR:
                begin
                    foreach (fb_live[i])
                        fb_live[i] = 1'b0;
                end
                OP_BLIT:
                begin
                    dx = int'(r.ox) + int'(r.scol);
                    dp = (int'(r.oy) >>> 3) + int'(r.spage);
                    sh = int'(r.oy) & 7;
                    lo_bits = r.sbyte << sh;
                    hi_bits = r.sbyte >> (8 - sh);
                    wrote = 1'b0;
                    if (dx >= 0 && dx < FB_COLUMNS)
                    begin
                        if (dp >= 0 && dp < FB_PAGES)
                        begin
                            merge_byte(dp, dx, lo_bits);
                            wrote = 1'b1;
                        end
                        if (sh != 0 && dp + 1 >= 0 && dp + 1 < FB_PAGES)
                        begin
                            merge_byte(dp + 1, dx, hi_bits);
                            wrote = 1'b1;
                        end
                    end
                    res.clip = !wrote;
                end
                OP_READ:
                begin
                    if (int'(r.raddr) < FB_DEPTH && fb_live[r.raddr])
                        res.data = fb_bytes[r.raddr];
                end
                default: ;
            endcase
            return res;
        end
    endfunction

    task automatic push_request(input logic [1:0] op, input int ox, input int oy, input int sp,
                                input int sc, input int sb, input int ra);
        draw_request_t r;
        begin
            r.op    = op;
            r.ox    = 9'(ox);
            r.oy    = 9'(oy);
            r.spage = 5'(sp);
            r.scol  = 8'(sc);
            r.sbyte = 8'(sb);
            r.raddr = 10'(ra);
            pending_requests.push_back(r);
        end
    endtask

    // Random request: mostly blits that land in the store and reads of bytes just drawn,
    // with clears often enough to wrap the generation tag, plus fully random noise.
    task automatic push_random_request();
        int kind, ox, oy, sp, sc, dx, dp;
        begin
            kind = $urandom_range(99);
            ox = int'($urandom_range(511)) - 256;
            oy = int'($urandom_range(511)) - 256;
            sp = $urandom_range(31);
            sc = $urandom_range(255);
            if (kind < 8)
                push_request(OP_CLEAR, ox, oy, sp, sc, $urandom, $urandom);
            else if (kind < 56)
            begin
                if ($urandom_range(9) < 8)
                begin
                    ox = int'($urandom_range(140)) - 10;
                    sc = $urandom_range(15);
                    oy = int'($urandom_range(82)) - 12;
                    sp = $urandom_range(3);
                end
                dx = ox + sc;
                dp = (oy >>> 3) + sp;
                if (dx >= 0 && dx < FB_COLUMNS && dp >= 0 && dp < FB_PAGES)
                begin
                    recent_addrs.push_back(dp * FB_COLUMNS + dx);
                    if (recent_addrs.size() > 32)
                        void'(recent_addrs.pop_front());
                end
                push_request(OP_BLIT, ox, oy, sp, sc, $urandom, $urandom);
            end
            else if (kind < 96)
            begin
                if (recent_addrs.size() != 0 && $urandom_range(9) < 6)
                    push_request(OP_READ, ox, oy, sp, sc, $urandom,
                                 recent_addrs[$urandom_range(recent_addrs.size() - 1)]);
                else
                    push_request(OP_READ, ox, oy, sp, sc, $urandom, $urandom);
            end
            else
                push_request(OP_UNUSED, ox, oy, sp, sc, $urandom, $urandom);
        end
    endtask

    // Driver: inputs change at the falling edge; a request is held until it is taken.
    always @(negedge clk)
    begin
        draw_request_t nxt;
        if (rst_n)
        begin
            if (start && !took_request)
                ;
            else if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                nxt = pending_requests.pop_front();
                start         <= 1'b1;
                operation     <= nxt.op;
                origin_x      <= nxt.ox;
                origin_y      <= nxt.oy;
                source_page   <= nxt.spage;
                source_column <= nxt.scol;
                source_byte   <= nxt.sbyte;
                read_address  <= nxt.raddr;
            end
            else
            begin
                // Idle cycle: the fields carry junk that must be ignored.
                start         <= 1'b0;
                operation     <= 2'($urandom);
                origin_x      <= 9'($urandom);
                origin_y      <= 9'($urandom);
                source_page   <= 5'($urandom);
                source_column <= 8'($urandom);
                source_byte   <= 8'($urandom);
                read_address  <= 10'($urandom);
            end
        end
    end

    // Monitor: check results and predict each accepted request at the rising edge.
    always @(posedge clk)
    begin
        draw_result_t want;
        draw_request_t seen;
        took_request = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.data)
                        report_mismatch($sformatf("read_data %0h, expected %0h",
                                                  read_data, want.data));
                    if (clipped !== want.clip)
                        report_mismatch($sformatf("clipped %0b, expected %0b",
                                                  clipped, want.clip));
                end
            end
            if (start && !busy)
            begin
                took_request = 1'b1;
                seen.op    = operation;
                seen.ox    = origin_x;
                seen.oy    = origin_y;
                seen.spage = source_page;
                seen.scol  = source_column;
                seen.sbyte = source_byte;
                seen.raddr = read_address;
                expected_results.push_back(draw_and_predict(seen));
            end
        end
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        int wait_cycles;
        foreach (fb_live[i])
        begin
            fb_live[i]  = 1'b0;
            fb_bytes[i] = '0;
        end

        // Directed requests: field extremes, clipping on each side, page split and spill.
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 0);
        push_request(OP_BLIT,     0,    0,  0,   0, 8'hFF, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 0);
        push_request(OP_BLIT,  -256, -256, 31, 255, 8'hA5, 0);
        push_request(OP_BLIT,   255,    0,  0,   0, 8'h5A, 0);
        push_request(OP_BLIT,    -1,   -1,  0, 128, 8'h81, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 127);
        push_request(OP_BLIT,   120,   60,  0,   7, 8'hFF, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 1023);
        push_request(OP_BLIT,     0,  255,  0,   0, 8'hFF, 0);
        push_request(OP_BLIT,     0,   -8,  1,   5, 8'h00, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 5);
        push_request(OP_BLIT,    10, -256, 31,   0, 8'hFF, 0);
        push_request(OP_BLIT,     2,    7,  0,   1, 8'hC3, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 3);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 131);
        push_request(OP_UNUSED,  -1,   -1, 31, 255, 8'hFF, 1023);
        push_request(OP_CLEAR,   -1,   -1, 31, 255, 8'hFF, 1023);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 1023);
        push_request(OP_BLIT,     0,    0,  0,   0, 8'h01, 0);
        push_request(OP_READ,     0,    0,  0,   0, 8'h00, 0);

        // Reset held low, then released at a falling edge.
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Three random phases: moderate sender gaps, heavy gaps, then back to back.
        idle_pct = 26;
        repeat (350) push_random_request();
        while (pending_requests.size() != 0) @(posedge clk);
        idle_pct = 58;
        repeat (350) push_random_request();
        while (pending_requests.size() != 0) @(posedge clk);
        idle_pct = 0;
        repeat (350) push_random_request();
        while (pending_requests.size() != 0 || start) @(posedge clk);

        // Let the last results drain, then wait on for stray strobes.
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < 200)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[page_bitmap_blitter.f]
rtl/pbb_pkg.sv
rtl/pbb_bank.sv
rtl/page_bitmap_blitter.sv
dv/page_bitmap_blitter_test.sv
